// ===== sv/rgb_led_pulse_frame_encoder_core_macros.svh =====
// Assertion helpers used by the encoder RTL.
`ifndef RGB_LED_PULSE_FRAME_ENCODER_CORE_MACROS_SVH
`define RGB_LED_PULSE_FRAME_ENCODER_CORE_MACROS_SVH

// Property must hold on every rising clock edge outside reset.
`define RLPFE_ASSERT_ALWAYS(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("rlpfe assertion failed");

// Same-cycle implication outside reset.
`define RLPFE_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rlpfe implication failed");

// Next-cycle implication outside reset.
`define RLPFE_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rlpfe next-cycle implication failed");

`endif

// ===== sv/rlpfe_pkg.sv =====
package rlpfe_pkg;

  localparam int unsigned DataBits        = 24;
  localparam int unsigned ResetSlots      = 80;
  localparam int unsigned TotalSlots      = DataBits + ResetSlots;
  localparam int unsigned SlotPosW        = $clog2(TotalSlots + 1);
  localparam int unsigned BitIdxW         = $clog2(DataBits);
  localparam logic [7:0]  BrightnessReset = 8'd255;

  localparam int unsigned PaddrW = 4;
  localparam int unsigned PdataW = 32;

  localparam logic [15:0] OneDutyReset  = 16'd136;
  localparam logic [15:0] ZeroDutyReset = 16'd68;

  typedef enum logic [1:0] {
    CmdSetColour = 2'd0,
    CmdSetBright = 2'd1,
    CmdPoll      = 2'd2,
    CmdTick      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RegOneDuty  = 2'd0,
    RegZeroDuty = 2'd1,
    RegRgbOrder = 2'd2
  } reg_e;

endpackage

// ===== sv/rlpfe_if.sv =====
interface rlpfe_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] brightness_value;

  modport source (output valid, command, red, green, blue, brightness_value, input ready);
  modport sink   (input valid, command, red, green, blue, brightness_value, output ready);
endinterface

interface rlpfe_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] slot_duty;
  logic        slot_valid;
  logic        frame_last;
  logic        busy_flag;
  logic        pending_flag;
  logic [7:0]  brightness_now;

  modport source (output valid, slot_duty, slot_valid, frame_last, busy_flag, pending_flag,
                  brightness_now, input ready);
  modport sink   (input valid, slot_duty, slot_valid, frame_last, busy_flag, pending_flag,
                  brightness_now, output ready);
endinterface

// ===== sv/rlpfe_scale.sv =====
module rlpfe_scale (
  input  logic [7:0] chan_i,
  input  logic [7:0] bright_i,
  output logic [7:0] scaled_o
);

  logic [15:0] prod;
  logic [16:0] biased;
  logic [16:0] corr;

  // round(c*b/255): (y + y/256 + 1) / 256 equals y / 255 for this range
  assign prod     = chan_i * bright_i;
  assign biased   = {1'b0, prod} + 17'd127;
  assign corr     = biased + {8'd0, biased[16:8]} + 17'd1;
  assign scaled_o = corr[15:8];

endmodule

// ===== sv/rgb_led_pulse_frame_encoder_core.sv =====
// Single-LED pulse-frame encoder. Each request (set colour, set brightness, poll start
// or slot tick) produces exactly one response, which sits in an output register, so
// with the response side ready a request is taken every clock. Set colour/brightness
// rescale each channel as (c*brightness+127)/255 with three small 8x8 multipliers and
// mark the frame pending; poll latches the packed word (GRB, or RGB when rgb_order is
// set) if a frame is pending and the block is idle. Each tick of a running frame yields
// one slot: 24 data slots, MSB first, at one_bit_duty or zero_bit_duty, then 80 reset
// slots at zero duty; frame_last flags the final one.
// Registers on APB: one_bit_duty at 0x0, zero_bit_duty at 0x4, rgb_order at 0x8;
// change them only while the block is idle.
`include "rgb_led_pulse_frame_encoder_core_macros.svh"

module rgb_led_pulse_frame_encoder_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rlpfe_req_if.sink                      req_i,
  rlpfe_rsp_if.source                    rsp_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rlpfe_pkg::PaddrW-1:0]   paddr,
  input  logic [rlpfe_pkg::PdataW-1:0]   pwdata,
  output logic [rlpfe_pkg::PdataW-1:0]   prdata,
  output logic                           pready
);

  localparam int unsigned PosW = rlpfe_pkg::SlotPosW;

  logic [15:0] one_duty_q, zero_duty_q;
  logic        rgb_order_q;

  logic [7:0]  red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic [7:0]  bright_q, bright_d;
  logic [23:0] target_q, target_d;
  logic [23:0] frame_q, frame_d;
  logic        pending_q, pending_d;
  logic        busy_q, busy_d;
  logic [PosW-1:0] pos_q, pos_d, pos_inc;

  logic        out_vld_q;
  logic [15:0] duty_q, duty_d;
  logic        sval_q, sval_d;
  logic        last_q, last_d;

  logic        accept;
  logic        rebuild;
  logic [7:0]  op_r, op_g, op_b, op_bright;
  logic [7:0]  sc_r, sc_g, sc_b;
  logic [rlpfe_pkg::BitIdxW-1:0] bit_idx;
  logic        cfg_wr;
  rlpfe_pkg::cmd_e cmd;
  rlpfe_pkg::reg_e reg_sel;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = rlpfe_pkg::reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_duty_q  <= rlpfe_pkg::OneDutyReset;
      zero_duty_q <= rlpfe_pkg::ZeroDutyReset;
      rgb_order_q <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_sel)
        rlpfe_pkg::RegOneDuty:  one_duty_q  <= pwdata[15:0];
        rlpfe_pkg::RegZeroDuty: zero_duty_q <= pwdata[15:0];
        rlpfe_pkg::RegRgbOrder: rgb_order_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      rlpfe_pkg::RegOneDuty:  prdata = {16'd0, one_duty_q};
      rlpfe_pkg::RegZeroDuty: prdata = {16'd0, zero_duty_q};
      rlpfe_pkg::RegRgbOrder: prdata = {31'd0, rgb_order_q};
      default:                prdata = '0;
    endcase
  end

  // Request handling
  assign req_i.ready = !out_vld_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign cmd         = rlpfe_pkg::cmd_e'(req_i.command);

  assign op_r      = (cmd == rlpfe_pkg::CmdSetColour) ? req_i.red   : red_q;
  assign op_g      = (cmd == rlpfe_pkg::CmdSetColour) ? req_i.green : green_q;
  assign op_b      = (cmd == rlpfe_pkg::CmdSetColour) ? req_i.blue  : blue_q;
  assign op_bright = (cmd == rlpfe_pkg::CmdSetBright) ? req_i.brightness_value : bright_q;

  rlpfe_scale u_scale_r (.chan_i(op_r), .bright_i(op_bright), .scaled_o(sc_r));
  rlpfe_scale u_scale_g (.chan_i(op_g), .bright_i(op_bright), .scaled_o(sc_g));
  rlpfe_scale u_scale_b (.chan_i(op_b), .bright_i(op_bright), .scaled_o(sc_b));

  assign pos_inc = pos_q + PosW'(1);
  assign bit_idx = rlpfe_pkg::BitIdxW'(rlpfe_pkg::DataBits - 1) - pos_q[rlpfe_pkg::BitIdxW-1:0];

  always_comb begin
    red_d     = red_q;
    green_d   = green_q;
    blue_d    = blue_q;
    bright_d  = bright_q;
    target_d  = target_q;
    frame_d   = frame_q;
    pending_d = pending_q;
    busy_d    = busy_q;
    pos_d     = pos_q;
    duty_d    = '0;
    sval_d    = 1'b0;
    last_d    = 1'b0;
    rebuild   = 1'b0;
    case (cmd)
      rlpfe_pkg::CmdSetColour: begin
        red_d   = req_i.red;
        green_d = req_i.green;
        blue_d  = req_i.blue;
        rebuild = 1'b1;
      end
      rlpfe_pkg::CmdSetBright: begin
        bright_d = req_i.brightness_value;
        rebuild  = 1'b1;
      end
      rlpfe_pkg::CmdPoll: begin
        if (pending_q && !busy_q) begin
          busy_d    = 1'b1;
          pending_d = 1'b0;
          frame_d   = target_q;
          pos_d     = '0;
        end
      end
      rlpfe_pkg::CmdTick: begin
        if (busy_q) begin
          sval_d = 1'b1;
          if (pos_q < PosW'(rlpfe_pkg::DataBits)) begin
            duty_d = frame_q[bit_idx] ? one_duty_q : zero_duty_q;
          end
          if (pos_inc == PosW'(rlpfe_pkg::TotalSlots)) begin
            last_d = 1'b1;
            busy_d = 1'b0;
            pos_d  = '0;
          end else begin
            pos_d = pos_inc;
          end
        end
      end
      default: ;
    endcase
    if (rebuild) begin
      target_d  = rgb_order_q ? {sc_r, sc_g, sc_b} : {sc_g, sc_r, sc_b};
      pending_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q     <= '0;
      green_q   <= '0;
      blue_q    <= '0;
      bright_q  <= rlpfe_pkg::BrightnessReset;
      target_q  <= '0;
      frame_q   <= '0;
      pending_q <= 1'b1;
      busy_q    <= 1'b0;
      pos_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        red_q     <= red_d;
        green_q   <= green_d;
        blue_q    <= blue_d;
        bright_q  <= bright_d;
        target_q  <= target_d;
        frame_q   <= frame_d;
        pending_q <= pending_d;
        busy_q    <= busy_d;
        pos_q     <= pos_d;
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      duty_q <= duty_d;
      sval_q <= sval_d;
      last_q <= last_d;
    end
  end

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.slot_duty      = duty_q;
  assign rsp_o.slot_valid     = sval_q;
  assign rsp_o.frame_last     = last_q;
  assign rsp_o.busy_flag      = busy_q;
  assign rsp_o.pending_flag   = pending_q;
  assign rsp_o.brightness_now = bright_q;

  `RLPFE_ASSERT_ALWAYS(a_pos_range, clk_i, rst_ni, pos_q < PosW'(rlpfe_pkg::TotalSlots))
  `RLPFE_ASSERT_IMPL(a_idle_pos_zero, clk_i, rst_ni, !busy_q, pos_q == '0)
  `RLPFE_ASSERT_IMPL(a_last_ends_frame, clk_i, rst_ni, out_vld_q && last_q, sval_q && !busy_q)
  `RLPFE_ASSERT_NEXT(a_poll_starts, clk_i, rst_ni,
                     accept && cmd == rlpfe_pkg::CmdPoll && pending_q && !busy_q,
                     busy_q && !pending_q && pos_q == '0)

endmodule

// ===== test/rgb_led_pulse_frame_encoder_core_tb.sv =====
module rgb_led_pulse_frame_encoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 4000;

  typedef enum logic {RowItem, RowFlush} row_kind_e;

  typedef struct packed {
    rlpfe_pkg::cmd_e cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] bright;
  } led_req_t;

  typedef struct packed {
    logic [15:0] duty;
    logic        slot_valid;
    logic        last;
    logic        busy;
    logic        pending;
    logic [7:0]  bright;
  } slot_rsp_t;

  typedef struct packed {
    logic      fixed;
    slot_rsp_t rsp;
  } req_note_t;

  typedef struct packed {
    row_kind_e kind;
    led_req_t  req;
    logic      fixed;
    slot_rsp_t rsp;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [rlpfe_pkg::PaddrW-1:0] paddr = '0;
  logic [rlpfe_pkg::PdataW-1:0] pwdata = '0;
  logic [rlpfe_pkg::PdataW-1:0] prdata;
  logic pready;

  rlpfe_req_if req ();
  rlpfe_rsp_if rsp ();

  rgb_led_pulse_frame_encoder_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rsp_o   (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [15:0] cfg_one_duty = rlpfe_pkg::OneDutyReset;
  logic [15:0] cfg_zero_duty = rlpfe_pkg::ZeroDutyReset;
  logic        cfg_rgb = 1'b0;
  logic [7:0]  led_r = '0, led_g = '0, led_b = '0;
  logic [7:0]  led_bright = rlpfe_pkg::BrightnessReset;
  logic [23:0] packed_word = '0;
  logic [23:0] sent_word = '0;
  logic        frame_pending = 1'b1;
  logic        frame_busy = 1'b0;
  int          slot_idx = 0;

  slot_rsp_t slot_rsp_q[$];
  req_note_t note_q[$];
  dir_row_t  dir_q[$];
  int        errors = 0;
  int        idle_cycles = 0;
  int        items_sent = 0;
  bit        idle_en = 1'b1;
  int        stall_left = 0;

  function automatic logic [7:0] scaled(logic [7:0] c);
    logic [16:0] prod;
    prod = {9'd0, c} * {9'd0, led_bright} + 17'd127;
    return 8'(prod / 17'd255);
  endfunction

  function automatic void repack();
    if (cfg_rgb) packed_word = {scaled(led_r), scaled(led_g), scaled(led_b)};
    else packed_word = {scaled(led_g), scaled(led_r), scaled(led_b)};
    frame_pending = 1'b1;
  endfunction

  function automatic slot_rsp_t encode_step(led_req_t r);
    slot_rsp_t o;
    o = '0;
    case (r.cmd)
      rlpfe_pkg::CmdSetColour: begin
        led_r = r.red;
        led_g = r.green;
        led_b = r.blue;
        repack();
      end
      rlpfe_pkg::CmdSetBright: begin
        led_bright = r.bright;
        repack();
      end
      rlpfe_pkg::CmdPoll: begin
        if (frame_pending && !frame_busy) begin
          frame_busy = 1'b1;
          frame_pending = 1'b0;
          sent_word = packed_word;
          slot_idx = 0;
        end
      end
      default: begin
        if (frame_busy) begin
          o.slot_valid = 1'b1;
          if (slot_idx < rlpfe_pkg::DataBits)
            o.duty = sent_word[rlpfe_pkg::DataBits-1-slot_idx] ? cfg_one_duty
                                                                : cfg_zero_duty;
          slot_idx++;
          if (slot_idx >= rlpfe_pkg::TotalSlots) begin
            o.last = 1'b1;
            frame_busy = 1'b0;
            slot_idx = 0;
          end
        end
      end
    endcase
    o.busy = frame_busy;
    o.pending = frame_pending;
    o.bright = led_bright;
    return o;
  endfunction

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // monitor: requests feed the predictor, responses are checked in order
  always @(posedge clk_i) begin
    slot_rsp_t e;
    req_note_t n;
    led_req_t  r;
    bit        moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (req.valid && req.ready) begin
        moved = 1'b1;
        r.cmd = rlpfe_pkg::cmd_e'(req.command);
        r.red = req.red;
        r.green = req.green;
        r.blue = req.blue;
        r.bright = req.brightness_value;
        n = note_q.pop_front();
        e = encode_step(r);
        if (n.fixed) e = n.rsp;
        slot_rsp_q.push_back(e);
      end
      if (rsp.valid && rsp.ready) begin
        moved = 1'b1;
        if (slot_rsp_q.size() == 0) begin
          $display("%0t: response with no request outstanding", $time);
          errors++;
        end else begin
          e = slot_rsp_q.pop_front();
          check_field("slot_duty", e.duty, rsp.slot_duty);
          check_field("slot_valid", 16'(e.slot_valid), 16'(rsp.slot_valid));
          check_field("frame_last", 16'(e.last), 16'(rsp.frame_last));
          check_field("busy_flag", 16'(e.busy), 16'(rsp.busy_flag));
          check_field("pending_flag", 16'(e.pending), 16'(rsp.pending_flag));
          check_field("brightness_now", 16'(e.bright), 16'(rsp.brightness_now));
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= StallLimit);
    $display("tb: failure");
    $finish;
  end

  // response side stalls
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        rsp.ready = 1'b0;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        rsp.ready = 1'b0;
        stall_left = $urandom_range(0, 7);
      end else begin
        rsp.ready = 1'b1;
      end
    end
  end

  function automatic led_req_t rand_req(rlpfe_pkg::cmd_e c);
    led_req_t r;
    r.cmd = c;
    r.red = 8'($urandom);
    r.green = 8'($urandom);
    r.blue = 8'($urandom);
    r.bright = 8'($urandom);
    return r;
  endfunction

  task automatic send_req(led_req_t r, logic fixed, slot_rsp_t e);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      req.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    note_q.push_back('{fixed, e});
    req.command = r.cmd;
    req.red = r.red;
    req.green = r.green;
    req.blue = r.blue;
    req.brightness_value = r.bright;
    req.valid = 1'b1;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req.valid = 1'b0;
    while (slot_rsp_q.size() != 0 || note_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic finish_frame();
    int left;
    wait_drained();
    left = frame_busy ? rlpfe_pkg::TotalSlots - slot_idx : 0;
    repeat (left) send_req(rand_req(rlpfe_pkg::CmdTick), 1'b0, '0);
    wait_drained();
  endtask

  task automatic apb_write(rlpfe_pkg::reg_e idx, logic [31:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = rlpfe_pkg::PaddrW'(int'(idx) * 4);
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      rlpfe_pkg::RegOneDuty:  cfg_one_duty = data[15:0];
      rlpfe_pkg::RegZeroDuty: cfg_zero_duty = data[15:0];
      default:                cfg_rgb = data[0];
    endcase
  endtask

  function automatic void row(row_kind_e k, rlpfe_pkg::cmd_e c, logic [7:0] r, logic [7:0] g,
                              logic [7:0] b, logic [7:0] br, logic fixed, slot_rsp_t e);
    dir_q.push_back('{k, '{c, r, g, b, br}, fixed, e});
  endfunction

  initial begin
    dir_row_t d;
    int target;
    int nset;
    int nticks;
    logic [15:0] one_v;
    logic [15:0] zero_v;
    logic order_v;

    req.valid = 1'b0;
    req.command = rlpfe_pkg::CmdSetColour;
    req.red = '0;
    req.green = '0;
    req.blue = '0;
    req.brightness_value = '0;

    // after reset: black frame pending, brightness at reset value
    row(RowItem, rlpfe_pkg::CmdTick, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
        '{16'd0, 1'b0, 1'b0, 1'b0, 1'b1, 8'd255});
    row(RowItem, rlpfe_pkg::CmdPoll, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1,
        '{16'd0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd255});
    row(RowItem, rlpfe_pkg::CmdPoll, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
        '{16'd0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd255});
    row(RowItem, rlpfe_pkg::CmdTick, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1,
        '{16'd68, 1'b1, 1'b0, 1'b1, 1'b0, 8'd255});
    // updates during a frame stay pending
    row(RowItem, rlpfe_pkg::CmdSetColour, 8'hff, 8'hff, 8'hff, 8'h00, 1'b1,
        '{16'd0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd255});
    row(RowItem, rlpfe_pkg::CmdSetBright, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
        '{16'd0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0});
    row(RowItem, rlpfe_pkg::CmdSetBright, 8'h00, 8'h00, 8'h00, 8'hff, 1'b1,
        '{16'd0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd255});
    row(RowItem, rlpfe_pkg::CmdTick, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
        '{16'd68, 1'b1, 1'b0, 1'b1, 1'b1, 8'd255});
    row(RowFlush, rlpfe_pkg::CmdTick, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
    // full white frame, then a rescaled colour frame
    row(RowItem, rlpfe_pkg::CmdPoll, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
        '{16'd0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd255});
    row(RowItem, rlpfe_pkg::CmdTick, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
        '{16'd136, 1'b1, 1'b0, 1'b1, 1'b0, 8'd255});
    row(RowItem, rlpfe_pkg::CmdSetColour, 8'hff, 8'h00, 8'h00, 8'h00, 1'b0, '0);
    row(RowItem, rlpfe_pkg::CmdSetBright, 8'h00, 8'h00, 8'h00, 8'h01, 1'b0, '0);
    row(RowItem, rlpfe_pkg::CmdSetBright, 8'h00, 8'h00, 8'h00, 8'h80, 1'b0, '0);
    row(RowItem, rlpfe_pkg::CmdSetColour, 8'hff, 8'h80, 8'h01, 8'h00, 1'b0, '0);
    row(RowItem, rlpfe_pkg::CmdPoll, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
    row(RowItem, rlpfe_pkg::CmdTick, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
    row(RowFlush, rlpfe_pkg::CmdTick, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
    row(RowItem, rlpfe_pkg::CmdPoll, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
    row(RowItem, rlpfe_pkg::CmdTick, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
    row(RowFlush, rlpfe_pkg::CmdTick, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
    // idle: tick ignored, poll with nothing pending does nothing
    row(RowItem, rlpfe_pkg::CmdTick, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1,
        '{16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd128});
    row(RowItem, rlpfe_pkg::CmdPoll, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
        '{16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd128});
    row(RowItem, rlpfe_pkg::CmdSetColour, 8'h00, 8'hff, 8'h00, 8'h00, 1'b0, '0);
    row(RowItem, rlpfe_pkg::CmdSetColour, 8'h01, 8'h01, 8'h01, 8'h00, 1'b0, '0);
    row(RowItem, rlpfe_pkg::CmdPoll, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
    row(RowFlush, rlpfe_pkg::CmdTick, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_q[i]) begin
      d = dir_q[i];
      if (d.kind == RowFlush) finish_frame();
      else send_req(d.req, d.fixed, d.rsp);
    end
    finish_frame();

    // frames run on across register changes; only outstanding requests and responses are drained
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin one_v = 16'hffff; zero_v = 16'h0000; order_v = 1'b1; end
        1: begin one_v = 16'h0000; zero_v = 16'hffff; order_v = 1'b0; end
        2: begin
          one_v = 16'($urandom_range(0, 65535));
          zero_v = 16'($urandom_range(0, 65535));
          order_v = 1'b1;
        end
        3: begin one_v = 16'd1; zero_v = 16'hfffe; order_v = 1'b1; end
        4: begin
          one_v = 16'($urandom_range(0, 65535));
          zero_v = 16'($urandom_range(0, 65535));
          order_v = 1'($urandom_range(0, 1));
        end
        default: begin
          one_v = rlpfe_pkg::OneDutyReset;
          zero_v = rlpfe_pkg::ZeroDutyReset;
          order_v = 1'b0;
          idle_en = 1'b0;
        end
      endcase
      wait_drained();
      apb_write(rlpfe_pkg::RegOneDuty, {16'd0, one_v});
      apb_write(rlpfe_pkg::RegZeroDuty, {16'd0, zero_v});
      apb_write(rlpfe_pkg::RegRgbOrder, {31'd0, order_v});

      target = items_sent + 25;
      while (items_sent < target) begin
        if ($urandom_range(0, 4) != 0) begin
          nset = $urandom_range(0, 2);
          repeat (nset)
            send_req(rand_req(rlpfe_pkg::cmd_e'($urandom_range(0, 1))), 1'b0, '0);
          send_req(rand_req(rlpfe_pkg::CmdPoll), 1'b0, '0);
          nticks = $urandom_range(1, 60);
          repeat (nticks) begin
            if ($urandom_range(0, 11) == 0)
              send_req(rand_req(rlpfe_pkg::cmd_e'($urandom_range(0, 2))), 1'b0, '0);
            else
              send_req(rand_req(rlpfe_pkg::CmdTick), 1'b0, '0);
          end
        end else begin
          repeat ($urandom_range(1, 5))
            send_req(rand_req(rlpfe_pkg::cmd_e'($urandom_range(0, 3))), 1'b0, '0);
        end
      end
    end
    wait_drained();

    repeat (5) @(negedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rlpfe_pkg.sv
sv/rlpfe_if.sv
sv/rlpfe_scale.sv
sv/rgb_led_pulse_frame_encoder_core.sv
test/rgb_led_pulse_frame_encoder_core_tb.sv
